// ----- design/dfsc_pkg.sv -----
package dfsc_pkg;

  localparam int HEADER_BYTES = 24;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

  localparam logic [7:0] MAGIC_0 = 8'h42;
  localparam logic [7:0] MAGIC_1 = 8'h53;
  localparam logic [7:0] MAGIC_2 = 8'h44;
  localparam logic [7:0] MAGIC_3 = 8'h50;

  localparam logic [15:0] VERSION_SUPPORTED = 16'd1;

  localparam int OFS_VERSION = 4;
  localparam int OFS_FLAGS   = 6;
  localparam int OFS_WIDTH   = 8;
  localparam int OFS_HEIGHT  = 10;
  localparam int OFS_TYPE    = 12;
  localparam int OFS_LENGTH  = 16;
  localparam int OFS_CRC     = 20;

  localparam int FLAG_COMPRESSED_BIT = 0;
  localparam int FLAG_CONFIDENCE_BIT = 1;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_BAD_HEADER  = 3'd1;
  localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] STATUS_BAD_VERSION = 3'd3;
  localparam logic [2:0] STATUS_SIZE        = 3'd4;
  localparam logic [2:0] STATUS_CRC         = 3'd5;

  localparam logic [1:0] TAG_DEPTH      = 2'd0;
  localparam logic [1:0] TAG_CONFIDENCE = 2'd1;
  localparam logic [1:0] TAG_COMPRESSED = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_value;
    logic [1:0]  plane_tag;
    logic [2:0]  status_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        is_compressed;
    logic        has_confidence_plane;
    logic        end_of_results;
  } out_item_t;

  typedef struct packed {
    logic        has_payload;
    logic        has_verdict;
    logic [7:0]  file_byte;
    logic [1:0]  plane_tag;
    logic [2:0]  status_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        is_compressed;
    logic        has_confidence_plane;
  } q_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/dfsc_front.sv -----
module dfsc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  dfsc_pkg::in_item_t in_data,
  output logic               in_full,
  input  logic               q_full,
  output logic               q_push,
  output dfsc_pkg::q_entry_t q_data
);
  import dfsc_pkg::*;

  logic [7:0]  hdr_r   [HEADER_BYTES];
  logic [7:0]  hdr_nxt [HEADER_BYTES];
  logic [31:0] cnt_r;
  logic [31:0] cnt_nxt;
  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] pix_r;
  logic [32:0] depth_r;
  logic [33:0] raw_r;

  logic        accept;
  logic        in_hdr;
  logic [31:0] offset;
  logic [31:0] payload_cnt;
  logic [1:0]  tag;
  logic [2:0]  status;

  logic [15:0] width_cur;
  logic [15:0] height_cur;
  logic        comp_cur;
  logic        conf_cur;

  logic [15:0] version_nxt;
  logic [15:0] type_nxt;
  logic [15:0] width_nxt;
  logic [15:0] height_nxt;
  logic [7:0]  flags_nxt;
  logic [31:0] length_nxt;
  logic [31:0] crc_hdr_nxt;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign in_hdr  = cnt_r < 32'(HEADER_BYTES);
  assign cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 32'd1;
  assign crc_nxt = in_hdr ? crc_r : crc_byte(crc_r, in_data.file_byte);

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_nxt[i] = (in_hdr && cnt_r == 32'(i)) ? in_data.file_byte : hdr_r[i];
    end
  end

  assign width_cur  = {hdr_r[OFS_WIDTH + 1], hdr_r[OFS_WIDTH]};
  assign height_cur = {hdr_r[OFS_HEIGHT + 1], hdr_r[OFS_HEIGHT]};
  assign comp_cur   = hdr_r[OFS_FLAGS][FLAG_COMPRESSED_BIT];
  assign conf_cur   = hdr_r[OFS_FLAGS][FLAG_CONFIDENCE_BIT];

  assign version_nxt = {hdr_nxt[OFS_VERSION + 1], hdr_nxt[OFS_VERSION]};
  assign type_nxt    = {hdr_nxt[OFS_TYPE + 1], hdr_nxt[OFS_TYPE]};
  assign width_nxt   = {hdr_nxt[OFS_WIDTH + 1], hdr_nxt[OFS_WIDTH]};
  assign height_nxt  = {hdr_nxt[OFS_HEIGHT + 1], hdr_nxt[OFS_HEIGHT]};
  assign flags_nxt   = hdr_nxt[OFS_FLAGS];
  assign length_nxt  = {hdr_nxt[OFS_LENGTH + 3], hdr_nxt[OFS_LENGTH + 2],
                        hdr_nxt[OFS_LENGTH + 1], hdr_nxt[OFS_LENGTH]};
  assign crc_hdr_nxt = {hdr_nxt[OFS_CRC + 3], hdr_nxt[OFS_CRC + 2],
                        hdr_nxt[OFS_CRC + 1], hdr_nxt[OFS_CRC]};

  assign offset      = cnt_r - 32'(HEADER_BYTES);
  assign payload_cnt = cnt_nxt - 32'(HEADER_BYTES);

  always_comb begin
    if (comp_cur) begin
      tag = TAG_COMPRESSED;
    end else if ({1'b0, offset} < depth_r) begin
      tag = TAG_DEPTH;
    end else begin
      tag = TAG_CONFIDENCE;
    end
  end

  always_comb begin
    if (cnt_nxt < 32'(HEADER_BYTES)) begin
      status = STATUS_BAD_HEADER;
    end else if (hdr_nxt[0] != MAGIC_0 || hdr_nxt[1] != MAGIC_1 ||
                 hdr_nxt[2] != MAGIC_2 || hdr_nxt[3] != MAGIC_3) begin
      status = STATUS_BAD_MAGIC;
    end else if (version_nxt != VERSION_SUPPORTED) begin
      status = STATUS_BAD_VERSION;
    end else if (type_nxt != 16'd0 || width_nxt == 16'd0 || height_nxt == 16'd0) begin
      status = STATUS_BAD_HEADER;
    end else if (cnt_nxt == COUNT_MAX || payload_cnt != length_nxt) begin
      status = STATUS_SIZE;
    end else if ((crc_nxt ^ CRC_INIT) != crc_hdr_nxt) begin
      status = STATUS_CRC;
    end else if (!flags_nxt[FLAG_COMPRESSED_BIT] && {2'b00, length_nxt} != raw_r) begin
      status = STATUS_SIZE;
    end else begin
      status = STATUS_OK;
    end
  end

  assign q_push = accept && (!in_hdr || in_data.final_byte);

  always_comb begin
    q_data.has_payload          = !in_hdr;
    q_data.has_verdict          = in_data.final_byte;
    q_data.file_byte            = in_data.file_byte;
    q_data.plane_tag            = tag;
    q_data.status_code          = status;
    q_data.image_width          = width_nxt;
    q_data.image_height         = height_nxt;
    q_data.is_compressed        = flags_nxt[FLAG_COMPRESSED_BIT];
    q_data.has_confidence_plane = flags_nxt[FLAG_CONFIDENCE_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= CRC_INIT;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (accept) begin
      if (in_data.final_byte) begin
        cnt_r <= '0;
        crc_r <= CRC_INIT;
        for (int i = 0; i < HEADER_BYTES; i++) begin
          hdr_r[i] <= '0;
        end
      end else begin
        cnt_r <= cnt_nxt;
        crc_r <= crc_nxt;
        hdr_r <= hdr_nxt;
      end
    end
  end

  // The size products trail the header fields through pix_r and then depth_r and raw_r; the payload
  // starts well after the width, height and flags bytes are captured.
  always_ff @(posedge clk) begin
    pix_r   <= {16'd0, width_cur} * {16'd0, height_cur};
    depth_r <= {pix_r, 1'b0};
    raw_r   <= {1'b0, pix_r, 1'b0} + (conf_cur ? {2'b00, pix_r} : 34'd0);
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (crc_r != CRC_INIT) |-> (cnt_r > 32'(HEADER_BYTES)))
    else $error("CRC changed before any payload byte was seen.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.final_byte) |=> (cnt_r == '0 && crc_r == CRC_INIT))
    else $error("Parser state not cleared after the last byte of a file.");

endmodule

// ----- design/dfsc_queue.sv -----
module dfsc_queue #(
  parameter int DEPTH = dfsc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dfsc_pkg::q_entry_t wr_data,
  output logic               full,
  input  logic               pop,
  output dfsc_pkg::q_entry_t rd_data,
  output logic               empty
);
  import dfsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("Queue occupancy exceeds its depth.");

endmodule

// ----- design/dfsc_back.sv -----
module dfsc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  dfsc_pkg::q_entry_t  q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output dfsc_pkg::out_item_t out_data
);
  import dfsc_pkg::*;

  logic phase_r;
  logic phase_nxt;
  logic both;
  logic verdict_now;
  logic take;

  assign both        = q_data.has_payload && q_data.has_verdict;
  assign verdict_now = q_data.has_verdict && (!q_data.has_payload || phase_r);
  assign out_empty   = q_empty;
  assign take        = out_pop && !q_empty;
  assign q_pop       = take && !(both && !phase_r);

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      phase_nxt = both && !phase_r;
    end
  end

  always_comb begin
    out_data.image_width          = q_data.image_width;
    out_data.image_height         = q_data.image_height;
    out_data.is_compressed        = q_data.is_compressed;
    out_data.has_confidence_plane = q_data.has_confidence_plane;
    if (verdict_now) begin
      out_data.result_kind    = KIND_VERDICT;
      out_data.payload_value  = 8'd0;
      out_data.plane_tag      = TAG_DEPTH;
      out_data.status_code    = q_data.status_code;
      out_data.end_of_results = 1'b1;
    end else begin
      out_data.result_kind    = KIND_PAYLOAD;
      out_data.payload_value  = q_data.file_byte;
      out_data.plane_tag      = q_data.plane_tag;
      out_data.status_code    = STATUS_OK;
      out_data.end_of_results = !q_data.has_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_empty && both))
    else $error("Verdict phase set without a two-result entry at the head.");

endmodule

// ----- design/depth_file_stream_checker.sv -----
// A transaction that yields results is pushed into the registered queue as it is accepted.
// Throughput: one file byte per cycle while in_full is low; the last payload byte of a file
// yields two results, taken over two pops, and a queue of QUEUE_DEPTH entries absorbs the difference.
// The CRC update, header capture and verdict of one byte complete in the cycle it is taken.
// Reset is synchronous and active low; it clears the parser state and the queue at once.
// After each verdict the parser returns to its reset state for the next file.
module depth_file_stream_checker #(
  parameter int QUEUE_DEPTH = dfsc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  dfsc_pkg::in_item_t  in_data,
  output logic                in_full,
  input  logic                out_pop,
  output dfsc_pkg::out_item_t out_data,
  output logic                out_empty
);
  import dfsc_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_wr_data;
  q_entry_t q_rd_data;

  dfsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  dfsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  dfsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Front pushed into a full queue.");

endmodule

// ----- tb/dfsc_stream_check.sv -----
module dfsc_stream_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  dfsc_pkg::in_item_t  in_data,
  input  logic                out_pop,
  input  logic                out_empty,
  input  dfsc_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import dfsc_pkg::*;

  localparam int PRINT_CAP = 60;

  logic [7:0]  header_bytes [HEADER_BYTES];
  logic [31:0] byte_count;
  logic [31:0] payload_crc;
  out_item_t   pending_results [$];

  function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] header_word(int pos);
    return {header_bytes[pos + 1], header_bytes[pos]};
  endfunction

  function automatic logic [31:0] header_long(int pos);
    return {header_word(pos + 2), header_word(pos)};
  endfunction

  function automatic out_item_t shape_result(logic kind, logic [7:0] value, logic [1:0] tag,
                                             logic [2:0] status, logic last);
    out_item_t r;
    logic [15:0] flags;
    flags = header_word(OFS_FLAGS);
    r.result_kind = kind;
    r.payload_value = value;
    r.plane_tag = tag;
    r.status_code = status;
    r.image_width = header_word(OFS_WIDTH);
    r.image_height = header_word(OFS_HEIGHT);
    r.is_compressed = flags[FLAG_COMPRESSED_BIT];
    r.has_confidence_plane = flags[FLAG_CONFIDENCE_BIT];
    r.end_of_results = last;
    return r;
  endfunction

  // Checks are taken in a fixed priority: the first failing one names the status.
  function automatic logic [2:0] file_status();
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] flags;
    logic [31:0] declared_len;
    logic [63:0] area;
    logic [63:0] raw_len;
    w = header_word(OFS_WIDTH);
    h = header_word(OFS_HEIGHT);
    flags = header_word(OFS_FLAGS);
    declared_len = header_long(OFS_LENGTH);
    if (byte_count < HEADER_BYTES) return STATUS_BAD_HEADER;
    if (header_bytes[0] != MAGIC_0 || header_bytes[1] != MAGIC_1 ||
        header_bytes[2] != MAGIC_2 || header_bytes[3] != MAGIC_3) return STATUS_BAD_MAGIC;
    if (header_word(OFS_VERSION) != VERSION_SUPPORTED) return STATUS_BAD_VERSION;
    if (header_word(OFS_TYPE) != 16'd0) return STATUS_BAD_HEADER;
    if (w == 16'd0 || h == 16'd0) return STATUS_BAD_HEADER;
    if (byte_count == COUNT_MAX) return STATUS_SIZE;
    if (byte_count - 32'(HEADER_BYTES) != declared_len) return STATUS_SIZE;
    if ((payload_crc ^ CRC_INIT) != header_long(OFS_CRC)) return STATUS_CRC;
    if (!flags[FLAG_COMPRESSED_BIT]) begin
      area = 64'(w) * 64'(h);
      raw_len = area * 2 + (flags[FLAG_CONFIDENCE_BIT] ? area : 64'd0);
      if (64'(declared_len) != raw_len) return STATUS_SIZE;
    end
    return STATUS_OK;
  endfunction

  task automatic restart_file();
    for (int i = 0; i < HEADER_BYTES; i++) begin
      header_bytes[i] = 8'd0;
    end
    byte_count = 32'd0;
    payload_crc = CRC_INIT;
  endtask

  task automatic absorb_file_byte(in_item_t item);
    logic [15:0] flags;
    logic [31:0] area;
    logic [32:0] depth_len;
    logic [31:0] offset;
    logic [1:0]  tag;
    if (byte_count < HEADER_BYTES) begin
      header_bytes[5'(byte_count)] = item.file_byte;
    end else begin
      flags = header_word(OFS_FLAGS);
      area = 32'(header_word(OFS_WIDTH)) * 32'(header_word(OFS_HEIGHT));
      depth_len = {area, 1'b0};
      offset = byte_count - 32'(HEADER_BYTES);
      if (flags[FLAG_COMPRESSED_BIT]) begin
        tag = TAG_COMPRESSED;
      end else if (33'(offset) < depth_len) begin
        tag = TAG_DEPTH;
      end else begin
        tag = TAG_CONFIDENCE;
      end
      payload_crc = crc32_step(payload_crc, item.file_byte);
      pending_results.insert(pending_results.size(),
                             shape_result(KIND_PAYLOAD, item.file_byte, tag, STATUS_OK,
                                          !item.final_byte));
    end
    if (byte_count != COUNT_MAX) begin
      byte_count = byte_count + 32'd1;
    end
    if (item.final_byte) begin
      pending_results.insert(pending_results.size(),
                             shape_result(KIND_VERDICT, 8'd0, TAG_DEPTH, file_status(),
                                          1'b1));
      restart_file();
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report("result with nothing expected", 64'(got), 64'd0);
    end else begin
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      if (got.payload_value !== want.payload_value)
        report("payload_value", 64'(got.payload_value), 64'(want.payload_value));
      if (got.plane_tag !== want.plane_tag)
        report("plane_tag", 64'(got.plane_tag), 64'(want.plane_tag));
      if (got.status_code !== want.status_code)
        report("status_code", 64'(got.status_code), 64'(want.status_code));
      if (got.image_width !== want.image_width)
        report("image_width", 64'(got.image_width), 64'(want.image_width));
      if (got.image_height !== want.image_height)
        report("image_height", 64'(got.image_height), 64'(want.image_height));
      if (got.is_compressed !== want.is_compressed)
        report("is_compressed", 64'(got.is_compressed), 64'(want.is_compressed));
      if (got.has_confidence_plane !== want.has_confidence_plane)
        report("has_confidence_plane", 64'(got.has_confidence_plane),
               64'(want.has_confidence_plane));
      if (got.end_of_results !== want.end_of_results)
        report("end_of_results", 64'(got.end_of_results), 64'(want.end_of_results));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_file();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_pop && !out_empty) begin
        compare_result(out_data);
      end
      if (in_push && !in_full) begin
        absorb_file_byte(in_data);
      end
    end
    pending <= pending_results.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import dfsc_pkg::*;

  localparam int BYTE_TARGET = 1200;
  localparam int CALM_AFTER  = 1000;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum {
    FILE_GOOD,
    FILE_SHORT,
    FILE_MAGIC,
    FILE_VERSION,
    FILE_DTYPE,
    FILE_ZERO_DIM,
    FILE_LENGTH,
    FILE_CRC,
    FILE_RAW,
    FILE_NOISE
  } file_kind_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  out_item_t out_data;
  logic      out_empty;

  int fail_count;
  int pending;
  int bytes_sent = 0;
  int pop_hold = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  int          pick;
  logic        comp;
  logic        conf;
  logic [15:0] w;
  logic [15:0] h;
  file_kind_t  kind;

  depth_file_stream_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

  dfsc_stream_check chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 8);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{file_byte: b, final_byte: fin};
    do @(posedge clk); while (in_full);
    bytes_sent++;
    calm = bytes_sent >= CALM_AFTER;
  endtask

  task automatic send_file(file_kind_t fk, logic cmp, logic cnf, logic [15:0] fw,
                           logic [15:0] fh, int packed_len);
    logic [7:0]   body [$];
    logic [7:0]   b;
    logic [191:0] head;
    logic [15:0]  ver;
    logic [15:0]  dtype;
    logic [15:0]  flags;
    logic [31:0]  hlen;
    logic [31:0]  hcrc;
    longint       raw;
    int           n;
    int           total;
    if (fk == FILE_NOISE) begin
      n = $urandom_range(1, 60);
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom), i == n - 1);
      end
    end else begin
      if (fk == FILE_ZERO_DIM) begin
        case ($urandom_range(0, 2))
          0: fw = 16'd0;
          1: fh = 16'd0;
          default: begin
            fw = 16'd0;
            fh = 16'd0;
          end
        endcase
      end
      raw = longint'(fw) * longint'(fh) * (cnf ? 3 : 2);
      n = cmp ? packed_len : int'(raw);
      if (fk == FILE_RAW) begin
        n = $urandom_range(0, 40);
        if (longint'(n) == raw) begin
          n++;
        end
      end
      hlen = 32'(n);
      if (fk == FILE_LENGTH) begin
        if (n == 0 || $urandom_range(0, 1) == 1) begin
          n = n + $urandom_range(1, 6);
        end else begin
          n = $urandom_range(0, n - 1);
        end
      end
      hcrc = CRC_INIT;
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        body.insert(body.size(), b);
        hcrc = crc_fold(hcrc, b);
      end
      hcrc = hcrc ^ CRC_INIT;
      if (fk == FILE_CRC) begin
        hcrc = hcrc ^ (32'd1 << $urandom_range(0, 31));
      end
      ver = VERSION_SUPPORTED;
      if (fk == FILE_VERSION) begin
        do ver = 16'($urandom); while (ver == VERSION_SUPPORTED);
      end
      dtype = (fk == FILE_DTYPE) ? 16'($urandom_range(1, 16'hFFFF)) : 16'd0;
      flags = 16'($urandom);
      flags[FLAG_COMPRESSED_BIT] = cmp;
      flags[FLAG_CONFIDENCE_BIT] = cnf;
      head = {hcrc, hlen, 16'($urandom), dtype, fh, fw, flags, ver,
              MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};
      if (fk == FILE_MAGIC) begin
        head[8 * $urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
      end
      total = (fk == FILE_SHORT) ? $urandom_range(1, HEADER_BYTES - 1) : HEADER_BYTES + n;
      for (int i = 0; i < total; i++) begin
        b = (i < HEADER_BYTES) ? head[8 * i +: 8] : body[i - HEADER_BYTES];
        send_byte(b, i == total - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_pop <= 1'b0;
      pop_hold <= $urandom_range(0, 7);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // A one-byte file, then each verdict and tagging case in turn.
    send_byte(8'hFF, 1'b1);
    send_file(FILE_SHORT, 1'b0, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_GOOD, 1'b0, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_GOOD, 1'b0, 1'b1, 16'd2, 16'd1, 0);
    send_file(FILE_GOOD, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 5);
    send_file(FILE_GOOD, 1'b1, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_MAGIC, 1'b0, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_VERSION, 1'b0, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_DTYPE, 1'b0, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_ZERO_DIM, 1'b0, 1'b0, 16'd1, 16'd1, 0);
    send_file(FILE_LENGTH, 1'b0, 1'b1, 16'd1, 16'd1, 0);
    send_file(FILE_CRC, 1'b0, 1'b0, 16'd1, 16'd2, 0);
    send_file(FILE_RAW, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 0);
    send_file(FILE_NOISE, 1'b0, 1'b0, 16'd1, 16'd1, 0);

    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) kind = FILE_GOOD;
      else if (pick < 64) kind = FILE_SHORT;
      else if (pick < 68) kind = FILE_MAGIC;
      else if (pick < 72) kind = FILE_VERSION;
      else if (pick < 76) kind = FILE_DTYPE;
      else if (pick < 80) kind = FILE_ZERO_DIM;
      else if (pick < 86) kind = FILE_LENGTH;
      else if (pick < 92) kind = FILE_CRC;
      else if (pick < 96) kind = FILE_RAW;
      else kind = FILE_NOISE;
      comp = ($urandom_range(0, 3) == 0);
      conf = 1'($urandom_range(0, 1));
      if (kind == FILE_RAW) begin
        comp = 1'b0;
      end
      if ((comp || kind == FILE_RAW) && $urandom_range(0, 3) == 0) begin
        w = 16'($urandom);
        h = 16'($urandom);
      end else begin
        w = 16'($urandom_range(1, 3));
        h = 16'($urandom_range(1, 3));
      end
      send_file(kind, comp, conf, w, h, $urandom_range(0, 40));
    end
    in_push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
